// ===== design/trd_pkg.sv =====
package trd_pkg;

    // Number of entries kept in the ring (1 to 63).
    localparam int RING_DEPTH = 32;
    localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    localparam logic [31:0] SEQ_MAX = 32'hFFFF_FFFF;

    // Operation codes.
    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_DRAIN  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Result item kinds.
    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [1:0]         operation;
        logic [47:0]        timestamp_us;
        logic [7:0]         op_code;
        logic signed [31:0] op_result;
        logic [31:0]        byte_count;
    } t_in_req;

    typedef struct packed {
        logic               item_kind;
        logic               is_last;
        logic [31:0]        entry_seq;
        logic [47:0]        entry_time;
        logic [7:0]         entry_op;
        logic signed [7:0]  entry_result;
        logic [31:0]        entry_bytes;
        logic [31:0]        lost_count;
        logic [31:0]        first_seq;
        logic [31:0]        last_seq;
        logic [5:0]         emitted_count;
        logic [31:0]        total_recorded;
    } t_out_item;

    // One stored ring entry. The sequence number is rebuilt while draining.
    typedef struct packed {
        logic [47:0]       time_us;
        logic [7:0]        op;
        logic signed [7:0] result;
        logic [31:0]       bytes;
    } t_slot;

    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] waddr;
        t_slot            wdata;
        logic             re;
        logic [PTR_W-1:0] raddr;
    } t_ram_req;

endpackage

// ===== design/trd_entry_ram.sv =====
module trd_entry_ram
    import trd_pkg::*;
(
    input  logic     i_clk,
    input  t_ram_req i_req,
    output t_slot    o_rdata
);

    t_slot r_mem [RING_DEPTH];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/trace_ring_record_drain_top.sv =====
// Trace ring that keeps the newest RING_DEPTH records and overwrites the
// oldest. A record request writes one entry of the ring memory unless the
// sequence counter is saturated, so records stream in at one per cycle
// while no drain runs. A drain request walks the ring: the span, clip and
// length steps work out the span of unread entries, then each drained entry
// takes a memory read, then the output register load, and the summary item
// takes the end check, then the output register load; a load waits while
// the output side stalls. The single-port read of the ring memory sets the
// per-entry cost. No request is taken while a drain runs.
// A clear request restarts the sequence numbering and the drain mark; the
// memory keeps its contents but is never read before being written again.
// Results leave through an output register, so a finished item may wait for
// the consumer while the block already takes the next request.
module trace_ring_record_drain_top
    import trd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_req   i_in_req,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SPAN  = 3'd1;
    localparam logic [2:0] S_CLIP  = 3'd2;
    localparam logic [2:0] S_LEN   = 3'd3;
    localparam logic [2:0] S_ISSUE = 3'd4;
    localparam logic [2:0] S_LOAD  = 3'd5;
    localparam logic [2:0] S_SUM   = 3'd6;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
    localparam logic [31:0]      DEPTH_32 = 32'(RING_DEPTH);
    localparam logic [31:0]      DEPTH_M1 = 32'(RING_DEPTH - 1);

    logic [2:0]       r_state, n_state;
    logic [31:0]      r_next_seq, n_next_seq;
    logic [31:0]      r_drained, n_drained;
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;

    // Drain working registers.
    logic [31:0]      r_end, n_end;
    logic [31:0]      r_start, n_start;
    logic [31:0]      r_oldest, n_oldest;
    logic [31:0]      r_lost, n_lost;
    logic [31:0]      r_q, n_q;
    logic [31:0]      r_last, n_last;
    logic [PTR_W-1:0] r_ptr, n_ptr;
    logic [5:0]       r_remain, n_remain;
    logic [5:0]       r_emitted, n_emitted;

    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    t_ram_req         ram_req;
    t_slot            ram_rdata;
    t_slot            rec_slot;
    logic             in_fire;
    logic             out_free;

    trd_entry_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Clamp the result to -127..127 before storing it.
    always_comb begin
        rec_slot.time_us = i_in_req.timestamp_us;
        rec_slot.op      = i_in_req.op_code;
        rec_slot.bytes   = i_in_req.byte_count;
        if (i_in_req.op_result < -32'sd127) begin
            rec_slot.result = -8'sd127;
        end else if (i_in_req.op_result > 32'sd127) begin
            rec_slot.result = 8'sd127;
        end else begin
            rec_slot.result = i_in_req.op_result[7:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_next_seq  = r_next_seq;
        n_drained   = r_drained;
        n_wptr      = r_wptr;
        n_rptr      = r_rptr;
        n_end       = r_end;
        n_start     = r_start;
        n_oldest    = r_oldest;
        n_lost      = r_lost;
        n_q         = r_q;
        n_last      = r_last;
        n_ptr       = r_ptr;
        n_remain    = r_remain;
        n_emitted   = r_emitted;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        ram_req       = '0;
        ram_req.waddr = r_wptr;
        ram_req.wdata = rec_slot;
        ram_req.raddr = r_ptr;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (i_in_req.operation)
                        OP_RECORD: begin
                            // A saturated sequence counter drops the record.
                            if (r_next_seq != SEQ_MAX) begin
                                ram_req.we = 1'b1;
                                n_next_seq = r_next_seq + 32'd1;
                                n_wptr     = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
                            end
                        end
                        OP_DRAIN: begin
                            n_end   = r_next_seq - 32'd1;
                            n_start = r_drained + 32'd1;
                            n_state = S_SPAN;
                        end
                        OP_CLEAR: begin
                            n_next_seq = 32'd1;
                            n_drained  = '0;
                            n_wptr     = '0;
                            n_rptr     = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SPAN: begin
                n_oldest = (r_end >= DEPTH_32) ? r_end - DEPTH_M1 : 32'd1;
                n_state  = S_CLIP;
            end
            S_CLIP: begin
                // Unread entries older than the ring are lost; the walk then
                // starts at the oldest slot, which is the next write slot.
                if (r_start < r_oldest) begin
                    n_lost  = r_oldest - r_start;
                    n_start = r_oldest;
                    n_ptr   = r_wptr;
                end else begin
                    n_lost = '0;
                    n_ptr  = r_rptr;
                end
                n_drained = r_end;
                n_rptr    = r_wptr;
                n_state   = S_LEN;
            end
            S_LEN: begin
                n_remain  = 6'(r_end + 32'd1 - r_start);
                n_q       = r_start;
                n_emitted = '0;
                n_last    = '0;
                n_state   = S_ISSUE;
            end
            S_ISSUE: begin
                if (r_remain == '0) begin
                    n_state = S_SUM;
                end else begin
                    ram_req.re = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                if (out_free) begin
                    n_out              = '0;
                    n_out.item_kind    = KIND_ENTRY;
                    n_out.entry_seq    = r_q;
                    n_out.entry_time   = ram_rdata.time_us;
                    n_out.entry_op     = ram_rdata.op;
                    n_out.entry_result = ram_rdata.result;
                    n_out.entry_bytes  = ram_rdata.bytes;
                    n_out_valid        = 1'b1;
                    n_last             = r_q;
                    n_q                = r_q + 32'd1;
                    n_ptr              = (r_ptr == PTR_LAST) ? '0 : r_ptr + 1'b1;
                    n_remain           = r_remain - 6'd1;
                    n_emitted          = r_emitted + 6'd1;
                    n_state            = S_ISSUE;
                end
            end
            S_SUM: begin
                if (out_free) begin
                    n_out                = '0;
                    n_out.item_kind      = KIND_SUMMARY;
                    n_out.is_last        = 1'b1;
                    n_out.lost_count     = r_lost;
                    n_out.first_seq      = (r_emitted != '0) ? r_start : '0;
                    n_out.last_seq       = r_last;
                    n_out.emitted_count  = r_emitted;
                    n_out.total_recorded = r_end;
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next_seq  <= 32'd1;
            r_drained   <= '0;
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_seq  <= n_next_seq;
            r_drained   <= n_drained;
            r_wptr      <= n_wptr;
            r_rptr      <= n_rptr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_end     <= n_end;
        r_start   <= n_start;
        r_oldest  <= n_oldest;
        r_lost    <= n_lost;
        r_q       <= n_q;
        r_last    <= n_last;
        r_ptr     <= n_ptr;
        r_remain  <= n_remain;
        r_emitted <= n_emitted;
        r_out     <= n_out;
    end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    import trd_pkg::*;

    // Operation code 3 has no meaning; the block must drop it without a result.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // The longest correct run stays far below this limit.
    localparam int CYCLE_LIMIT = 400000;

    // Every pause adds this settling wait after the last owed result, so that
    // the block sits idle before the next burst.
    localparam int SETTLE_CYCLES = 20;

    // Reference copy of the trace ring. It tracks the sequence counter, the
    // drain mark and the stored entries, and turns each accepted request into
    // the list of items the block should return.
    class ring_tracker;
        t_slot     ring[RING_DEPTH];
        logic [31:0] next_seq;
        logic [31:0] drained_thru;
        t_out_item due_items[$];
        int        errors;

        function new();
            foreach (ring[i]) ring[i] = '0;
            next_seq     = 32'd1;
            drained_thru = 32'd0;
            errors       = 0;
        endfunction

        function int pending();
            return due_items.size();
        endfunction

        function logic signed [7:0] clamp_to_byte(input logic signed [31:0] raw);
            if (raw < -32'sd127) begin
                return -8'sd127;
            end
            if (raw > 32'sd127) begin
                return 8'sd127;
            end
            return raw[7:0];
        endfunction

        function void note_request(input t_in_req req);
            longint    fin_q;
            longint    start_q;
            longint    oldest_q;
            longint    lost_q;
            longint    first_q;
            longint    last_q;
            longint    q;
            int        n;
            int        idx;
            t_out_item item;

            case (req.operation)
                OP_RECORD: begin
                    if (next_seq != SEQ_MAX) begin
                        fin_q = next_seq;
                        idx = int'((fin_q - 1) % RING_DEPTH);
                        ring[idx].time_us = req.timestamp_us;
                        ring[idx].op      = req.op_code;
                        ring[idx].result  = clamp_to_byte(req.op_result);
                        ring[idx].bytes   = req.byte_count;
                        next_seq = next_seq + 32'd1;
                    end
                end
                OP_CLEAR: begin
                    next_seq     = 32'd1;
                    drained_thru = 32'd0;
                end
                OP_DRAIN: begin
                    fin_q = next_seq;
                    fin_q = fin_q - 1;
                    start_q = drained_thru;
                    start_q = start_q + 1;
                    oldest_q = (fin_q >= RING_DEPTH) ? fin_q - RING_DEPTH + 1 : 1;
                    lost_q = 0;
                    first_q = 0;
                    last_q = 0;
                    n = 0;
                    if (start_q < oldest_q) begin
                        lost_q  = oldest_q - start_q;
                        start_q = oldest_q;
                    end
                    drained_thru = fin_q[31:0];
                    for (q = start_q; q <= fin_q && n < RING_DEPTH; q++) begin
                        idx = int'((q - 1) % RING_DEPTH);
                        item = '0;
                        item.item_kind    = KIND_ENTRY;
                        item.entry_seq    = q[31:0];
                        item.entry_time   = ring[idx].time_us;
                        item.entry_op     = ring[idx].op;
                        item.entry_result = ring[idx].result;
                        item.entry_bytes  = ring[idx].bytes;
                        due_items.push_back(item);
                        if (first_q == 0) begin
                            first_q = q;
                        end
                        last_q = q;
                        n++;
                    end
                    item = '0;
                    item.item_kind      = KIND_SUMMARY;
                    item.is_last        = 1'b1;
                    item.lost_count     = lost_q[31:0];
                    item.first_seq      = first_q[31:0];
                    item.last_seq       = last_q[31:0];
                    item.emitted_count  = n[5:0];
                    item.total_recorded = fin_q[31:0];
                    due_items.push_back(item);
                end
                default: begin
                end
            endcase
        endfunction

        function void field_ok(input string name, input logic [63:0] want,
                               input logic [63:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_item(input t_out_item got);
            t_out_item want;
            if (due_items.size() == 0) begin
                $error("result item arrived with no expectation waiting");
                errors++;
                return;
            end
            want = due_items.pop_front();
            field_ok("item_kind", want.item_kind, got.item_kind);
            field_ok("is_last", want.is_last, got.is_last);
            field_ok("entry_seq", want.entry_seq, got.entry_seq);
            field_ok("entry_time", want.entry_time, got.entry_time);
            field_ok("entry_op", want.entry_op, got.entry_op);
            field_ok("entry_result", want.entry_result, got.entry_result);
            field_ok("entry_bytes", want.entry_bytes, got.entry_bytes);
            field_ok("lost_count", want.lost_count, got.lost_count);
            field_ok("first_seq", want.first_seq, got.first_seq);
            field_ok("last_seq", want.last_seq, got.last_seq);
            field_ok("emitted_count", want.emitted_count, got.emitted_count);
            field_ok("total_recorded", want.total_recorded, got.total_recorded);
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_req   in_req;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;

    // Percentages of cycles in which the sender holds back a request and the
    // receiver refuses a result. The main sequence changes them per phase.
    int send_gap_pct;
    int take_stall_pct;
    int cycle_count;

    ring_tracker tracker;

    trace_ring_record_drain_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    // Period of four time units, two high and two low.
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The receiver decides at each falling edge whether it takes a result at
    // the next rising edge.
    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= take_stall_pct);
    end

    // Every result taken at a rising edge goes straight to the tracker, which
    // compares it with the oldest item still owed.
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            tracker.check_item(out_item);
        end
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Timestamps lean toward the two ends of the 48-bit range.
    function automatic logic [47:0] pick_time();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            default: return wide[47:0];
        endcase
    endfunction

    // Results are often chosen right at the clamp limits, since that is where
    // the stored value is most likely to be wrong.
    function automatic logic signed [31:0] pick_result();
        case ($urandom_range(12))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return -32'sd128;
            3: return -32'sd127;
            4: return -32'sd126;
            5: return 32'sd126;
            6: return 32'sd127;
            7: return 32'sd128;
            8, 9: return 32'(int'($urandom_range(400)) - 200);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_bytes();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return $urandom_range(1500);
            default: return $urandom;
        endcase
    endfunction

    // Fields that a drain or a clear ignores are still filled with random
    // values, so that the block is seen to ignore them.
    function automatic t_in_req make_request(input logic [1:0] op);
        t_in_req req;
        req.operation    = op;
        req.timestamp_us = pick_time();
        req.op_code      = 8'($urandom_range(255));
        req.op_result    = pick_result();
        req.byte_count   = pick_bytes();
        return req;
    endfunction

    function automatic t_in_req make_record(input logic [47:0] ts, input logic [7:0] code,
                                            input logic signed [31:0] res,
                                            input logic [31:0] nbytes);
        t_in_req req;
        req.operation    = OP_RECORD;
        req.timestamp_us = ts;
        req.op_code      = code;
        req.op_result    = res;
        req.byte_count   = nbytes;
        return req;
    endfunction

    // Presents one request and holds it until the block takes it. The task is
    // entered and left at a falling edge. Valid is lowered only when the
    // sender chooses a gap, so back-to-back requests keep it high.
    task automatic send_request(input t_in_req req);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_req   = req;
        do begin
            @(posedge i_clk);
        end while (!in_ready);
        tracker.note_request(req);
        @(negedge i_clk);
    endtask

    // Stops sending until every owed result has come back, then leaves the
    // block idle for the settling wait.
    task automatic settle();
        in_valid = 1'b0;
        while (tracker.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Random traffic is mostly bursts of records closed by a drain, as the
    // traced datapath produces it. Some bursts are longer than the ring so
    // that entries are lost before the drain reads them. Clears, lone drains
    // and requests with the unused operation code are mixed in as noise.
    task automatic run_random(input int quota);
        int done_cnt;
        int burst;
        int pick;
        done_cnt = 0;
        while (done_cnt < quota) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                burst = ($urandom_range(6) == 0) ? $urandom_range(70, 30) : $urandom_range(12);
                repeat (burst) send_request(make_request(OP_RECORD));
                send_request(make_request(OP_DRAIN));
                done_cnt += burst + 1;
            end else if (pick < 83) begin
                send_request(make_request(OP_CLEAR));
                done_cnt++;
            end else if (pick < 91) begin
                send_request(make_request(OP_UNUSED));
            end else begin
                send_request(make_request(OP_DRAIN));
                done_cnt++;
            end
        end
    endtask

    initial begin
        tracker        = new();
        i_rst_n        = 1'b0;
        in_valid       = 1'b0;
        in_req         = '0;
        out_ready      = 1'b0;
        send_gap_pct   = 31;
        take_stall_pct = 67;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. A drain right after reset must give a bare summary.
        send_request(make_request(OP_DRAIN));
        // Records at both ends of every field, and results around the clamp.
        send_request(make_record('0, 8'd0, 32'sh8000_0000, '0));
        send_request(make_record('1, 8'd255, 32'sh7FFF_FFFF, '1));
        send_request(make_record(48'h1, 8'h5A, -32'sd128, 32'h1));
        send_request(make_record(48'h8000_0000_0000, 8'hA5, -32'sd127, 32'h8000_0000));
        send_request(make_record(48'h7FFF_FFFF_FFFF, 8'h01, 32'sd127, 32'h7FFF_FFFF));
        send_request(make_record(48'h0000_FFFF_0000, 8'h80, 32'sd128, 32'h0000_FFFF));
        send_request(make_record(48'hFFFF_0000_FFFF, 8'h7F, -32'sd1, 32'hFFFF_0000));
        send_request(make_record(48'h5555_5555_5555, 8'h55, 32'sd0, 32'h5555_5555));
        // The unused operation code with every field bit set must be dropped.
        send_request('1);
        send_request(make_request(OP_DRAIN));
        // A second drain with nothing recorded in between is empty.
        send_request(make_request(OP_DRAIN));
        send_request(make_request(OP_CLEAR));
        // After a clear the counters start over although the ring keeps data.
        send_request(make_request(OP_DRAIN));
        send_request(make_record(48'hAAAA_AAAA_AAAA, 8'hAA, 32'sd1, 32'hAAAA_AAAA));
        send_request(make_record(48'h0123_4567_89AB, 8'h3C, 32'sd126, 32'h0BAD_F00D));
        send_request(make_request(OP_DRAIN));
        send_request(make_request(OP_RECORD));
        send_request(make_request(OP_CLEAR));
        send_request(make_request(OP_UNUSED));
        send_request(make_request(OP_RECORD));
        send_request(make_request(OP_DRAIN));
        settle();

        run_random(60);
        settle();

        send_gap_pct   = 67;
        take_stall_pct = 31;
        run_random(60);
        settle();

        send_gap_pct   = 0;
        take_stall_pct = 0;
        run_random(55);
        settle();

        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
